// ----- sv/skbs_pkg.sv -----
// Package for the sorted-key lookup block: table sizes, codes, word types.
// No dependencies; imported by sorted_key_binary_search_lookup.
package skbs_pkg;

  localparam int TABLE_DEPTH = 65536;
  localparam int OFFSET_BITS = 24;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = IDX_W + 1;
  localparam int COUNT_W = 17;
  localparam int CMP_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam int KEY_W     = 21;
  localparam int LDIDX_W   = 16;
  localparam int OFFFLD_W  = 24;
  localparam int ENTRY_W   = KEY_W + 2 * OFFSET_BITS;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    op_t                 op;
    logic [LDIDX_W-1:0]  load_index;
    logic [KEY_W-1:0]    codepoint;
    logic [OFFFLD_W-1:0] name_offset_in;
    logic [OFFFLD_W-1:0] annot_offset_in;
  } in_word_t;

  typedef struct packed {
    logic                found;
    logic [LDIDX_W-1:0]  entry_index;
    logic [OFFFLD_W-1:0] name_offset;
    logic [OFFFLD_W-1:0] annot_offset;
  } out_word_t;

endpackage

// ----- sv/sorted_key_binary_search_lookup.sv -----
// Binary-search lookup over a sorted table held in one synchronous memory.
// Load words give no result; a lookup makes P probes (at most IDX_W+1 = 17),
// one probe per cycle, bounded by the single read port of the table memory.
// The result strobe rises the cycle after the last probe; the receiver cannot stall.
// Synchronous active-low reset clears control state and entry_count; table undefined.
module sorted_key_binary_search_lookup
  import skbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_word_t           in_word,
  output logic               out_valid,
  output out_word_t          out_word,
  input  logic               cfg_we,
  input  logic [COUNT_W-1:0] cfg_wdata
);

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

  state_t             state_r, state_nxt;
  logic [COUNT_W-1:0] entry_count_r;
  logic [CNT_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0]   mid_r, mid_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [ENTRY_W-1:0] rd_q;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_r, out_nxt;

  logic               accept, is_lookup, wr_en;
  logic [CMP_W-1:0]   ld_ext;
  logic [CNT_W-1:0]   n_clamped;
  logic [CNT_W:0]     sum0, sum_s;
  logic [IDX_W-1:0]   rd_addr;
  logic [KEY_W-1:0]   probe_key;
  logic               key_lt, key_gt, key_eq;
  logic [CNT_W-1:0]   lo_s, hi_s;
  logic               more;
  logic [ENTRY_W-1:0] wr_data;

  assign accept    = start && !busy;
  assign is_lookup = (in_word.op == OP_LOOKUP);
  assign busy      = (state_r == ST_SEARCH);

  // Clamp the searched count to the table depth.
  assign n_clamped = (CMP_W'(entry_count_r) > CMP_W'(TABLE_DEPTH)) ?
                     CNT_W'(TABLE_DEPTH) : CNT_W'(entry_count_r);
  assign sum0      = {1'b0, CNT_W'(0)} + {1'b0, n_clamped};

  assign ld_ext  = CMP_W'(in_word.load_index);
  assign wr_en   = accept && !is_lookup && (ld_ext < CMP_W'(TABLE_DEPTH));
  assign wr_data = {in_word.codepoint,
                    OFFSET_BITS'(32'(in_word.name_offset_in)),
                    OFFSET_BITS'(32'(in_word.annot_offset_in))};

  // Compare the word read for mid_r and narrow the window.
  assign probe_key = rd_q[ENTRY_W-1 -: KEY_W];
  assign key_lt    = key_r < probe_key;
  assign key_gt    = key_r > probe_key;
  assign key_eq    = !key_lt && !key_gt;
  assign lo_s      = key_gt ? (CNT_W'(mid_r) + CNT_W'(1)) : lo_r;
  assign hi_s      = key_lt ? CNT_W'(mid_r) : hi_r;
  assign sum_s     = {1'b0, lo_s} + {1'b0, hi_s};
  assign more      = !key_eq && (lo_s < hi_s);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_lookup && (n_clamped != CNT_W'(0))) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!more) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_addr       = sum_s[IDX_W:1];
    unique case (state_r)
      ST_IDLE: begin
        rd_addr = sum0[IDX_W:1];
        if (accept && is_lookup) begin
          lo_nxt  = CNT_W'(0);
          hi_nxt  = n_clamped;
          mid_nxt = sum0[IDX_W:1];
          key_nxt = in_word.codepoint;
          // Empty table: miss right away.
          if (n_clamped == CNT_W'(0)) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
          end
        end
      end
      ST_SEARCH: begin
        lo_nxt  = lo_s;
        hi_nxt  = hi_s;
        mid_nxt = sum_s[IDX_W:1];
        if (!more) begin
          out_valid_nxt = 1'b1;
          if (key_eq) begin
            out_nxt.found        = 1'b1;
            out_nxt.entry_index  = LDIDX_W'(CMP_W'(mid_r));
            out_nxt.name_offset  = OFFFLD_W'(32'(rd_q[OFFSET_BITS +: OFFSET_BITS]));
            out_nxt.annot_offset = OFFFLD_W'(32'(rd_q[0 +: OFFSET_BITS]));
          end else begin
            out_nxt = '0;
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ld_ext[IDX_W-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  a_window_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (lo_r < hi_r) && (hi_r <= CNT_W'(TABLE_DEPTH)))
    else $error("search window empty or beyond table");

  a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (CNT_W'(mid_r) >= lo_r) && (CNT_W'(mid_r) < hi_r))
    else $error("probe index outside search window");

  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && (in_word.op == OP_LOOKUP)))
    else $error("search started without a lookup word");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.found) |->
      (out_word.entry_index == '0) && (out_word.name_offset == '0) &&
      (out_word.annot_offset == '0))
    else $error("miss result carries nonzero fields");

endmodule

// ----- verif/tb_top.sv -----
// Testbench for sorted_key_binary_search_lookup: directed table walk, then random
// load/lookup phases checked against an in-bench binary-search predictor.
// Depends on skbs_pkg and the sorted_key_binary_search_lookup RTL.
module tb_top;
  import skbs_pkg::*;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int ITEM_TARGET    = 1000;
  localparam int SETTLE_CYCLES  = 24;
  localparam int DRAIN_CYCLES   = 40;
  // Sorted key map: stride 31 leaves gaps for misses, the top entry lands on 21'h1FFFFF.
  localparam int KEY_STRIDE = 31;
  localparam int KEY_BASE   = 65566;

  typedef struct {
    bit                 is_cfg;
    logic [COUNT_W-1:0] count;
    in_word_t           word;
    bit                 typed;
    out_word_t          want;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_word_t           in_word;
  logic               out_valid;
  out_word_t          out_word;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;

  // Predictor copy of the table and the count register.
  logic [KEY_W-1:0]       key_mem   [TABLE_DEPTH];
  logic [OFFSET_BITS-1:0] name_mem  [TABLE_DEPTH];
  logic [OFFSET_BITS-1:0] annot_mem [TABLE_DEPTH];
  bit                     loaded    [TABLE_DEPTH];
  logic [COUNT_W-1:0]     table_count;

  out_word_t   pending_results[$];
  dir_row_t    dir_rows[$];
  int          errors;
  int unsigned cycle_cnt;
  bit          burst_mode;
  int          scrambled_hi;
  int          items_sent;

  sorted_key_binary_search_lookup u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic int map_key(input int idx);
    return idx * KEY_STRIDE + KEY_BASE;
  endfunction

  // Walk the probe sequence; return 0 with the index of the first probe into
  // an entry that was never loaded.
  function automatic bit search_table(input logic [KEY_W-1:0] key, output out_word_t res,
                                      output int hole);
    int lo;
    int hi;
    int mid;
    res  = '0;
    hole = -1;
    lo   = 0;
    hi   = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (!loaded[mid]) begin
        hole = mid;
        return 1'b0;
      end
      if (key < key_mem[mid]) begin
        hi = mid;
      end else if (key > key_mem[mid]) begin
        lo = mid + 1;
      end else begin
        res.found        = 1'b1;
        res.entry_index  = LDIDX_W'(mid);
        res.name_offset  = OFFFLD_W'(name_mem[mid]);
        res.annot_offset = OFFFLD_W'(annot_mem[mid]);
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance with start
  // still high, so the caller drives start again in that same step.
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    int        gap;
    int        roll;
    int        hole;
    out_word_t pred;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 45) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(4, 20);
    end
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    in_word = w;
    do @(posedge clk); while (busy);
    items_sent++;
    if (w.op == OP_LOAD) begin
      key_mem[w.load_index]   = w.codepoint;
      name_mem[w.load_index]  = OFFSET_BITS'(w.name_offset_in);
      annot_mem[w.load_index] = OFFSET_BITS'(w.annot_offset_in);
      loaded[w.load_index]    = 1'b1;
    end else if (typed) begin
      pending_results.push_back(want);
    end else begin
      void'(search_table(w.codepoint, pred, hole));
      pending_results.push_back(pred);
    end
    @(negedge clk);
  endtask

  task automatic load_entry(input int idx, input int key);
    in_word_t w;
    w.op              = OP_LOAD;
    w.load_index      = LDIDX_W'(idx);
    w.codepoint       = KEY_W'(key);
    w.name_offset_in  = OFFFLD_W'($urandom);
    w.annot_offset_in = OFFFLD_W'($urandom);
    send_word(w, 1'b0, '0);
  endtask

  // Fill every unloaded entry on the probe path with its mapped key first.
  task automatic look_up(input int key);
    in_word_t  w;
    out_word_t res;
    int        hole;
    while (!search_table(KEY_W'(key), res, hole)) load_entry(hole, map_key(hole));
    w.op              = OP_LOOKUP;
    w.load_index      = LDIDX_W'($urandom);
    w.codepoint       = KEY_W'(key);
    w.name_offset_in  = OFFFLD_W'($urandom);
    w.annot_offset_in = OFFFLD_W'($urandom);
    send_word(w, 1'b0, '0);
  endtask

  task automatic write_count(input int value);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // A load still in flight gives no result; let it drain.
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = COUNT_W'(value);
    @(negedge clk);
    cfg_we      = 1'b0;
    table_count = COUNT_W'(value);
  endtask

  task automatic add_cfg(input int value);
    dir_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.count  = COUNT_W'(value);
    dir_rows.push_back(r);
  endtask

  task automatic add_load(input int idx, input int key, input int name_off, input int annot_off);
    dir_row_t r;
    r                      = '{default: '0};
    r.word.op              = OP_LOAD;
    r.word.load_index      = LDIDX_W'(idx);
    r.word.codepoint       = KEY_W'(key);
    r.word.name_offset_in  = OFFFLD_W'(name_off);
    r.word.annot_offset_in = OFFFLD_W'(annot_off);
    dir_rows.push_back(r);
  endtask

  task automatic add_lookup(input int key, input bit typed, input bit hit, input int idx,
                            input int name_off, input int annot_off);
    dir_row_t r;
    r                      = '{default: '0};
    r.word.op              = OP_LOOKUP;
    r.word.load_index      = '1;
    r.word.codepoint       = KEY_W'(key);
    r.word.name_offset_in  = '1;
    r.word.annot_offset_in = '1;
    r.typed                = typed;
    r.want.found           = hit;
    r.want.entry_index     = LDIDX_W'(idx);
    r.want.name_offset     = OFFFLD_W'(name_off);
    r.want.annot_offset    = OFFFLD_W'(annot_off);
    dir_rows.push_back(r);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none, got %0h", $time, out_word);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("found", 32'(want.found), 32'(out_word.found));
        check_field("entry_index", 32'(want.entry_index), 32'(out_word.entry_index));
        check_field("name_offset", 32'(want.name_offset), 32'(out_word.name_offset));
        check_field("annot_offset", 32'(want.annot_offset), 32'(out_word.annot_offset));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("sorted_key_binary_search_lookup test failed");
      $finish;
    end
  end

  initial begin
    int sel;
    int n;
    int span;
    int runs;
    int roll;
    int idx;
    int key;
    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_word        = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    table_count    = '0;
    errors         = 0;
    burst_mode     = 1'b0;
    items_sent     = 0;
    // Directed entries 0..2 hold keys off the sorted map.
    scrambled_hi   = 3;

    // Empty table after reset, then the key and offset extremes.
    add_lookup(0, 1'b1, 1'b0, 0, 0, 0);
    add_lookup(21'h1FFFFF, 1'b1, 1'b0, 0, 0, 0);
    add_load(0, 0, 24'hFFFFFF, 0);
    add_load(1, 21'h1FFFFF, 0, 24'hFFFFFF);
    add_cfg(2);
    add_lookup(0, 1'b1, 1'b1, 0, 24'hFFFFFF, 0);
    add_lookup(21'h1FFFFF, 1'b1, 1'b1, 1, 0, 24'hFFFFFF);
    add_lookup(21'h155555, 1'b1, 1'b0, 0, 0, 0);
    add_cfg(1);
    add_lookup(21'h1FFFFF, 1'b1, 1'b0, 0, 0, 0);
    add_lookup(0, 1'b1, 1'b1, 0, 24'hFFFFFF, 0);
    // Duplicate and out-of-order keys.
    add_load(1, 5, 24'h123456, 24'h654321);
    add_load(2, 5, 24'hAAAAAA, 24'h555555);
    add_load(0, 100, 24'h0F0F0F, 24'hF0F0F0);
    add_cfg(3);
    add_lookup(5, 1'b0, 1'b0, 0, 0, 0);
    add_lookup(100, 1'b0, 1'b0, 0, 0, 0);
    add_lookup(4, 1'b0, 1'b0, 0, 0, 0);
    add_cfg(0);
    add_lookup(5, 1'b1, 1'b0, 0, 0, 0);

    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_count(dir_rows[i].count);
      end else begin
        send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      sel        = $urandom_range(0, 11);
      burst_mode = ($urandom_range(0, 3) == 0);
      runs       = $urandom_range(20, 50);
      if (sel >= 10) begin
        // Scrambled low region with repeated keys.
        n = $urandom_range(1, 32);
        write_count(n);
        for (int i = 0; i < n; i++) load_entry(i, $urandom_range(0, 31));
        if (n > scrambled_hi) scrambled_hi = n;
        while (runs > 0 && items_sent < ITEM_TARGET) begin
          runs--;
          roll = $urandom_range(0, 9);
          if (roll == 0) begin
            load_entry($urandom_range(0, n - 1), $urandom_range(0, 31));
          end else begin
            look_up((roll < 4) ? int'($urandom_range(0, 21'h1FFFFF)) : int'($urandom_range(0, 31)));
          end
        end
      end else begin
        case (sel)
          0: n = 0;
          1: n = 1;
          2: n = 2;
          3, 4, 5: n = $urandom_range(3, 64);
          6: n = $urandom_range(65, TABLE_DEPTH - 2);
          7: n = TABLE_DEPTH - 1;
          8: n = TABLE_DEPTH;
          default: n = ($urandom_range(0, 3) == 0) ? 131071 : $urandom_range(TABLE_DEPTH + 1, 131071);
        endcase
        write_count(n);
        // Restore the sorted map over any scrambled entries.
        for (int i = 0; i < scrambled_hi; i++) load_entry(i, map_key(i));
        scrambled_hi = 0;
        span = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
        while (runs > 0 && items_sent < ITEM_TARGET) begin
          runs--;
          roll = $urandom_range(0, 99);
          if (roll < 10) begin
            idx = $urandom_range(0, TABLE_DEPTH - 1);
            load_entry(idx, map_key(idx));
          end else begin
            roll = $urandom_range(0, 99);
            if (span > 0 && roll < 50) begin
              key = map_key($urandom_range(0, span - 1));
            end else if (span > 0 && roll < 65) begin
              key = (map_key($urandom_range(0, span - 1)) + $urandom_range(1, KEY_STRIDE - 1))
                    & 21'h1FFFFF;
            end else if (roll < 75) begin
              key = $urandom_range(0, KEY_BASE - 1);
            end else if (roll < 80) begin
              key = 0;
            end else if (roll < 85) begin
              key = 21'h1FFFFF;
            end else begin
              key = $urandom_range(0, 21'h1FFFFF);
            end
            look_up(key);
          end
        end
      end
    end

    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("sorted_key_binary_search_lookup test passed");
    end else begin
      $display("sorted_key_binary_search_lookup test failed");
    end
    $finish;
  end

endmodule
